>>> src/bffa_pkg.sv
// shared types and constants for the first-fit bitmap allocator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package bffa_pkg;

  localparam int MAP_BYTES_DEF = 512;
  localparam int START_MAX = 4095;

  localparam logic [9:0] BYTES_RESET = 10'd512;
  localparam logic REG_BYTES_IN_USE = 1'b0;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_TEST   = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;
  localparam logic [1:0] ACT_WRITE  = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] bit_pos;
    logic        bit_value;
    logic [12:0] run_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] start_index;
    logic        tested_bit;
  } rsp_t;

  typedef struct packed {
    logic take;
    logic sweep;
    logic scan;
    logic rd_bit;
    logic wr_bit;
    logic cap_bit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic       sweep_last;
    logic       scan_last;
    logic       hit;
    logic       skip;
    logic       range_err;
    logic       out_busy;
    logic [1:0] action;
  } sts_t;

endpackage

>>> src/bffa_ctrl.sv
// controller state machine of the allocator
// depends on bffa_pkg; drives bffa_dp through cmd_t and reads sts_t
`timescale 1ns / 1ps

module bffa_ctrl
  import bffa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_action,
  output logic       req_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_CLEAR  = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_DRAIN  = 8'b0001_0000,
    S_READ   = 8'b0010_0000,
    S_MODIFY = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take = 1'b1;
          case (req_action)
            ACT_CLEAR:  state_next = S_CLEAR;
            ACT_SEARCH: state_next = S_SCAN;
            default:    state_next = S_READ;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_next = S_RESP;
      end
      S_SCAN: begin
        if (sts.skip || sts.hit) begin
          state_next = S_RESP;
        end else begin
          cmd.scan = 1'b1;
          if (sts.scan_last) state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_RESP;
      end
      S_READ: begin
        if (sts.range_err) begin
          state_next = S_RESP;
        end else begin
          cmd.rd_bit = 1'b1;
          state_next = S_MODIFY;
        end
      end
      S_MODIFY: begin
        cmd.cap_bit = 1'b1;
        cmd.wr_bit = (sts.action == ACT_WRITE);
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

>>> src/bffa_dp.sv
// datapath of the allocator: byte store, request and result registers, run search
// depends on bffa_pkg; commanded by bffa_ctrl
`timescale 1ns / 1ps

module bffa_dp
  import bffa_pkg::*;
#(
  parameter int MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [9:0] bytes_in_use,
  input  req_t       req_data,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic       rsp_ready,
  output logic       rsp_valid,
  output rsp_t       rsp_data
);

  localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int LIVE_MAX = (MAP_BYTES < 1023) ? MAP_BYTES : 1023;
  localparam int CNT_W = $clog2(LIVE_MAX + 1);
  localparam int POS_W = ADDR_W + 3;
  localparam int CMP_W = 18;

  logic [7:0]        mem [MAP_BYTES];
  logic [7:0]        rdata;
  req_t              req_q;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] rd_addr_q;
  logic              rd_vld;
  logic [12:0]       run;
  logic              hit_q;
  logic [POS_W:0]    start_q;
  logic              tested_q;
  rsp_t              rsp_next;

  logic [CNT_W-1:0]  live;
  logic [13:0]       total;
  logic [ADDR_W-1:0] byte_sel;
  logic [7:0]        wr_byte;
  logic              we;
  logic              re;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        wdata;
  logic              proc;
  logic [12:0]       run_v;
  logic              hit_v;
  logic [2:0]        off_v;
  logic [POS_W:0]    start_v;
  logic              free_lo;
  logic [3:0]        zeros;

  always_comb begin
    live = (CMP_W'(bytes_in_use) > CMP_W'(MAP_BYTES)) ? CNT_W'(MAP_BYTES)
                                                       : CNT_W'(bytes_in_use);
    total = 14'(live) << 3;
    byte_sel = ADDR_W'(req_q.bit_pos[11:3]);
  end

  // store ports
  always_comb begin
    wr_byte = rdata;
    wr_byte[req_q.bit_pos[2:0]] = req_q.bit_value;
    we = cmd.sweep | cmd.wr_bit;
    waddr = cmd.sweep ? addr : byte_sel;
    wdata = cmd.sweep ? 8'h00 : wr_byte;
    re = cmd.scan | cmd.rd_bit;
    raddr = cmd.scan ? addr : byte_sel;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // run search over one byte, each bit position checked in parallel
  always_comb begin
    run_v = run;
    hit_v = 1'b0;
    off_v = 3'd0;
    free_lo = 1'b1;
    zeros = 4'd0;
    for (int b = 0; b < 8; b++) begin
      if (rdata[b]) begin
        free_lo = 1'b0;
        zeros = 4'd0;
        run_v = 13'd0;
      end else begin
        zeros = zeros + 4'd1;
        run_v = free_lo ? run + 13'(b + 1) : 13'(zeros);
      end
      if (!hit_v && run_v == req_q.run_length) begin
        hit_v = 1'b1;
        off_v = 3'(b);
      end
    end
    start_v = (POS_W + 1)'({rd_addr_q, off_v}) + (POS_W + 1)'(1)
            - (POS_W + 1)'(req_q.run_length);
    proc = rd_vld & ~hit_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      rd_vld <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
      if (cmd.take) begin
        addr <= '0;
        hit_q <= 1'b0;
      end else begin
        if (cmd.sweep || cmd.scan) addr <= addr + ADDR_W'(1);
        if (proc && hit_v) hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_q <= req_data;
      run <= 13'd0;
    end else if (proc) begin
      run <= run_v;
    end
    if (proc && hit_v) start_q <= start_v;
    if (cmd.scan) rd_addr_q <= addr;
    if (cmd.cap_bit) tested_q <= rdata[req_q.bit_pos[2:0]];
  end

  // result
  always_comb begin
    rsp_next = '0;
    case (req_q.action)
      ACT_CLEAR: begin
        rsp_next.status = ST_DONE;
      end
      ACT_TEST: begin
        if (sts.range_err) rsp_next.status = ST_RANGE;
        else rsp_next.tested_bit = tested_q;
      end
      ACT_SEARCH: begin
        if (hit_q && !(start_q > (POS_W + 1)'(START_MAX))) begin
          rsp_next.start_index = 12'(start_q);
        end else begin
          rsp_next.status = ST_NONE;
        end
      end
      default: begin
        if (sts.range_err) rsp_next.status = ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) rsp_data <= rsp_next;
  end

  always_comb begin
    sts.sweep_last = (CMP_W'(addr) == CMP_W'(MAP_BYTES - 1));
    sts.scan_last = (CMP_W'(addr) == CMP_W'(live) - CMP_W'(1));
    sts.hit = hit_q;
    sts.skip = (req_q.run_length == 13'd0) || (14'(req_q.run_length) > total);
    sts.range_err = (10'(req_q.bit_pos[11:3]) >= 10'(live));
    sts.out_busy = rsp_valid & ~rsp_ready;
    sts.action = req_q.action;
  end

endmodule

>>> src/bitmap_first_fit_allocator_unit.sv
// test or write bit: read the byte, capture the bit (a write stores the byte), load the result;
// out of range it loads at once; clear zeroes all MAP_BYTES bytes first; a search with a zero
// or too long run loads at once, else scans bytes in use to the run's end, or all and a drain
// one request at a time, taken the cycle after its result is loaded; a stalled result holds it
// reset: bytes_in_use returns to 512 and a clearing pass over every byte zeroes the store,
// during which no request is taken; configuration writes are taken at all times
`timescale 1ns / 1ps

module bitmap_first_fit_allocator_unit
  import bffa_pkg::*;
#(
  parameter int MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req_data,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp_data
);

  logic [9:0] bytes_in_use;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= BYTES_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BYTES_IN_USE) begin
      bytes_in_use <= pwdata[9:0];
    end
  end

  assign prdata = (paddr[2] == REG_BYTES_IN_USE) ? 32'(bytes_in_use) : 32'd0;

  bffa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_action (req_data.action),
    .req_ready  (req_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bffa_dp #(
    .MAP_BYTES (MAP_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .bytes_in_use (bytes_in_use),
    .req_data     (req_data),
    .cmd          (cmd),
    .sts          (sts),
    .rsp_ready    (rsp_ready),
    .rsp_valid    (rsp_valid),
    .rsp_data     (rsp_data)
  );

endmodule

>>> src/bffa_checker.sv
// port-level checks of the allocator results
// depends on bffa_pkg; bound to bitmap_first_fit_allocator_unit
`timescale 1ns / 1ps

module bffa_checker
  import bffa_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.status == ST_DONE || rsp_data.status == ST_NONE ||
                   rsp_data.status == ST_RANGE))
    else $error("unknown status code");

  a_fail_no_start: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_DONE |-> rsp_data.start_index == 12'd0 &&
                                                !rsp_data.tested_bit)
    else $error("failed request carries data");

  a_tested_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.tested_bit |-> rsp_data.start_index == 12'd0)
    else $error("tested bit with start index");

endmodule

bind bitmap_first_fit_allocator_unit bffa_checker u_bffa_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

>>> tb/bitmap_first_fit_allocator_unit_tb.sv
// self-checking testbench for the first-fit page-occupancy bitmap allocator
// depends on bffa_pkg and bitmap_first_fit_allocator_unit; keeps its own copy of the map
// and checks every response against it, over several map sizes and idling patterns
`timescale 1ns / 1ps

module bitmap_first_fit_allocator_unit_tb;
  import bffa_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_REQUESTS = 160;

  class occupancy_predictor;
    bit [7:0] page_map [MAP_BYTES_DEF];
    int unsigned bytes_in_use;
    rsp_t expected_rsps [$];
    int unsigned mismatches;

    function new();
      foreach (page_map[k]) page_map[k] = 8'h00;
      bytes_in_use = BYTES_RESET;
      mismatches = 0;
    endfunction

    function void set_bytes_in_use(int unsigned v);
      bytes_in_use = v & 32'h3ff;
    endfunction

    function int unsigned live_bits();
      return ((bytes_in_use > MAP_BYTES_DEF) ? MAP_BYTES_DEF : bytes_in_use) * 8;
    endfunction

    function int unsigned outstanding();
      return expected_rsps.size();
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int unsigned total;
      int unsigned pos;
      int unsigned run;
      int unsigned first;
      bit found;
      e = '0;
      total = live_bits();
      case (r.action)
        ACT_CLEAR: begin
          foreach (page_map[k]) page_map[k] = 8'h00;
        end
        ACT_TEST: begin
          if (r.bit_pos >= total) e.status = ST_RANGE;
          else e.tested_bit = page_map[r.bit_pos[11:3]][r.bit_pos[2:0]];
        end
        ACT_SEARCH: begin
          found = 1'b0;
          run = 0;
          first = 0;
          if (r.run_length != 0 && r.run_length <= total) begin
            for (pos = 0; pos < total && !found; pos++) begin
              if (page_map[pos >> 3][pos & 7]) run = 0;
              else run++;
              if (run == r.run_length) begin
                found = 1'b1;
                first = pos + 1 - r.run_length;
              end
            end
          end
          if (!found || first > START_MAX) e.status = ST_NONE;
          else e.start_index = 12'(first);
        end
        ACT_WRITE: begin
          if (r.bit_pos >= total) e.status = ST_RANGE;
          else page_map[r.bit_pos[11:3]][r.bit_pos[2:0]] = r.bit_value;
        end
      endcase
      expected_rsps.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_rsps.size() == 0) begin
        $error("response with none outstanding: status %0d start_index %0d tested_bit %0d",
               got.status, got.start_index, got.tested_bit);
        mismatches++;
        return;
      end
      e = expected_rsps.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        mismatches++;
      end
      if (got.start_index !== e.start_index) begin
        $error("start_index: expected %0d, actual %0d", e.start_index, got.start_index);
        mismatches++;
      end
      if (got.tested_bit !== e.tested_bit) begin
        $error("tested_bit: expected %0d, actual %0d", e.tested_bit, got.tested_bit);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req_data = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp_data;

  occupancy_predictor pred;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles = 0;

  bitmap_first_fit_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) pred.note_request(req_data);
      if (rsp_valid && rsp_ready) pred.check_response(rsp_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("bitmap_first_fit_allocator_unit_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic req_t mk_req(logic [1:0] action, int unsigned idx, logic val,
                                  int unsigned len);
    req_t r;
    r.action = action;
    r.bit_pos = 12'(idx);
    r.bit_value = val;
    r.run_length = 13'(len);
    return r;
  endfunction

  function automatic req_t rand_request(int unsigned total);
    req_t r;
    int unsigned pick;
    int unsigned window;
    pick = $urandom_range(0, 99);
    if (pick < 2) r.action = ACT_CLEAR;
    else if (pick < 27) r.action = ACT_TEST;
    else if (pick < 57) r.action = ACT_SEARCH;
    else r.action = ACT_WRITE;
    case ($urandom_range(0, 2))
      0: window = 63;
      1: window = 255;
      default: window = 4095;
    endcase
    pick = $urandom_range(0, 99);
    if (total == 0 || pick < 10) r.bit_pos = 12'($urandom_range(0, 4095));
    else if (pick < 17) r.bit_pos = 12'(total - 1 + $urandom_range(0, 2));
    else r.bit_pos = 12'($urandom_range(0, (window < total - 1) ? window : total - 1));
    r.bit_value = ($urandom_range(0, 99) < 75);
    pick = $urandom_range(0, 99);
    if (pick < 50) r.run_length = 13'($urandom_range(1, 16));
    else if (pick < 65) r.run_length = 13'($urandom_range(1, (total == 0) ? 1 : total));
    else if (pick < 72) r.run_length = '0;
    else if (pick < 85) r.run_length = 13'(total + $urandom_range(0, 3) - 1);
    else r.run_length = 13'($urandom_range(0, 8191));
    return r;
  endfunction

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  task automatic send(req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pred.outstanding() != 0);
  endtask

  task automatic write_bytes_in_use(int unsigned v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_BYTES_IN_USE);
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pred.set_bytes_in_use(v);
  endtask

  task automatic run_random(int n);
    int sent;
    int unsigned top;
    int unsigned k;
    int b;
    sent = 0;
    while (sent < n) begin
      // fill a whole byte now and then so full bytes show up in the map
      if (pred.live_bits() >= 8 && $urandom_range(0, 99) < 8) begin
        top = pred.live_bits() / 8 - 1;
        if (top > 31) top = 31;
        k = $urandom_range(0, top);
        for (b = 0; b < 8; b++) send(mk_req(ACT_WRITE, k * 8 + b, 1'b1, $urandom));
        sent += 8;
      end else begin
        send(rand_request(pred.live_bits()));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned sizes [9];
    int i;
    int b;
    pred = new();
    sizes = '{1, 0, 1023, 700, 3, $urandom_range(1, 512), 64, 512, $urandom_range(0, 1023)};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_idling(0);

    send(mk_req(ACT_TEST, 0, 1'b0, 0));
    send(mk_req(ACT_WRITE, 0, 1'b1, 0));
    send(mk_req(ACT_WRITE, 4095, 1'b1, 8191));
    send(mk_req(ACT_TEST, 4095, 1'b1, 0));
    send(mk_req(ACT_TEST, 0, 1'b0, 0));
    send(mk_req(ACT_SEARCH, 0, 1'b0, 0));
    send(mk_req(ACT_SEARCH, 4095, 1'b1, 1));
    send(mk_req(ACT_SEARCH, 0, 1'b0, 4094));
    send(mk_req(ACT_SEARCH, 0, 1'b0, 4095));
    send(mk_req(ACT_SEARCH, 0, 1'b0, 8191));
    for (b = 8; b < 16; b++) send(mk_req(ACT_WRITE, b, 1'b1, 0));
    send(mk_req(ACT_SEARCH, 0, 1'b0, 7));
    send(mk_req(ACT_SEARCH, 0, 1'b0, 8));
    send(mk_req(ACT_WRITE, 0, 1'b0, 0));
    send(mk_req(ACT_CLEAR, 4095, 1'b1, 8191));
    send(mk_req(ACT_TEST, 4095, 1'b0, 0));
    wait_drained();

    for (i = 0; i < 9; i++) begin
      write_bytes_in_use(sizes[i]);
      set_idling(i % 4);
      run_random(PHASE_REQUESTS);
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (pred.mismatches == 0) begin
      $display("bitmap_first_fit_allocator_unit_tb: done, clean");
    end else begin
      $display("bitmap_first_fit_allocator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
